// File: rtl/core/rpi_pkg.sv
`default_nettype none
package rpi_pkg;

    localparam int CW          = 21;
    localparam int DW          = CW + 1;
    localparam int NW          = 2 * DW + 1;
    localparam int NMW         = NW - 1;
    localparam int NS_MAG      = 15;
    localparam int NSW         = NS_MAG + 1;
    localparam int SHW         = 6;
    localparam int NSQW        = 32;
    localparam int RHSW        = 64;
    localparam int DENW        = 38;
    localparam int DMAGW       = DENW - 1;
    localparam int NUMW        = 40;
    localparam int NMAGW       = NUMW - 1;
    localparam int PAR_SCALE   = 10000;
    localparam int LHSW        = 51;
    localparam int SQW         = 64;
    localparam int TQ_FRAC     = 16;
    localparam int XW          = 60;
    localparam int QB          = 32;
    localparam int DSW         = DMAGW + QB;
    localparam int QFW         = QB + 3;
    localparam int KW          = 63;
    localparam int TQW         = 32;
    localparam int PLANE_STAGES = 7;
    localparam int CFG_IDXW    = 3;
    localparam int CFG_DW      = 3 * CW;
    localparam int COORD_FRAC_BITS_DEF = 10;

    typedef enum logic [CFG_IDXW-1:0] {
        REG_VERTEX_A  = 3'd0,
        REG_VERTEX_B  = 3'd1,
        REG_VERTEX_C  = 3'd2,
        REG_VERTEX_D  = 3'd3,
        REG_QUAD_MODE = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_PARALLEL = 2'd1,
        ST_BEHIND   = 2'd2,
        ST_OUTSIDE  = 2'd3
    } t_status;

    typedef logic [2:0][CW-1:0] t_vec;

    typedef struct packed {
        t_vec [3:0]               vert;
        logic [3:0][2:0][DW-1:0]  side_u;
        logic [2:0][NSW-1:0]      ns;
        logic [RHSW-1:0]          rhs;
        logic                     degen;
        logic                     quad;
    } t_plane;

    typedef struct packed {
        t_vec       p0;
        logic [2:0] dir_neg;
        logic       parallel;
        logic       behind;
    } t_side;

    function automatic logic [DW-1:0] csub(input logic [CW-1:0] x, input logic [CW-1:0] y);
        return DW'($signed(x)) - DW'($signed(y));
    endfunction

    function automatic logic [NW-1:0] xprod(input logic [DW-1:0] a, input logic [DW-1:0] b,
                                            input logic [DW-1:0] c, input logic [DW-1:0] d);
        return NW'($signed(a)) * NW'($signed(b)) - NW'($signed(c)) * NW'($signed(d));
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/rpi_plane.sv
`default_nettype none
module rpi_plane import rpi_pkg::*; #(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_IDXW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0]   i_cfg_data,
    output t_plane              o_plane,
    output logic                o_busy
);
    localparam int CNTW = $clog2(PLANE_STAGES + 1);

    logic [3:0][CFG_DW-1:0]  r_vert;
    logic                    r_quad;
    logic [CNTW-1:0]         r_cnt;
    t_vec [3:0]              vv;

    logic [2:0][DW-1:0]      r_e1, r_e2, n_e1, n_e2;
    logic [3:0][2:0][DW-1:0] r_u, n_u;
    logic [2:0][NW-1:0]      r_n, n_n;
    logic [2:0][NMW-1:0]     r_mag, n_mag;
    logic [2:0]              r_sgn;
    logic [NMW-1:0]          r_m, n_m;
    logic [SHW-1:0]          r_s, n_s;
    logic                    r_degen;
    logic [2:0][NSW-1:0]     r_ns, n_ns;
    logic [NSQW-1:0]         r_nsq, n_nsq;
    logic [RHSW-1:0]         r_rhs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vert <= '0;
            r_quad <= 1'b0;
            r_cnt  <= CNTW'(PLANE_STAGES);
        end else if (i_cfg_we) begin
            r_cnt <= CNTW'(PLANE_STAGES);
            unique case (t_reg_idx'(i_cfg_index))
                REG_VERTEX_A:  r_vert[0] <= i_cfg_data;
                REG_VERTEX_B:  r_vert[1] <= i_cfg_data;
                REG_VERTEX_C:  r_vert[2] <= i_cfg_data;
                REG_VERTEX_D:  r_vert[3] <= i_cfg_data;
                REG_QUAD_MODE: r_quad    <= i_cfg_data[0];
                default: ;
            endcase
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign vv     = r_vert;
    assign o_busy = i_cfg_we || (r_cnt != '0);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_e1[i]    = csub(vv[2][i], vv[1][i]);
            n_e2[i]    = csub(vv[0][i], vv[1][i]);
            n_u[0][i]  = csub(vv[1][i], vv[0][i]);
            n_u[1][i]  = csub(vv[2][i], vv[1][i]);
            n_u[2][i]  = r_quad ? csub(vv[3][i], vv[2][i]) : csub(vv[0][i], vv[2][i]);
            n_u[3][i]  = csub(vv[0][i], vv[3][i]);
        end
        n_n[0] = xprod(r_e1[1], r_e2[2], r_e1[2], r_e2[1]);
        n_n[1] = xprod(r_e1[2], r_e2[0], r_e1[0], r_e2[2]);
        n_n[2] = xprod(r_e1[0], r_e2[1], r_e1[1], r_e2[0]);
    end

    always_comb begin
        logic [NW-1:0] neg;
        n_m = '0;
        for (int i = 0; i < 3; i++) begin
            neg      = -r_n[i];
            n_mag[i] = r_n[i][NW-1] ? neg[NMW-1:0] : r_n[i][NMW-1:0];
            if (n_mag[i] > n_m) begin
                n_m = n_mag[i];
            end
        end
    end

    always_comb begin
        logic [SHW-1:0] hb;
        hb = '0;
        for (int b = 0; b < NMW; b++) begin
            if (r_m[b]) begin
                hb = SHW'(b + 1);
            end
        end
        n_s = (hb > SHW'(NS_MAG)) ? hb - SHW'(NS_MAG) : '0;
    end

    always_comb begin
        logic [NMW-1:0] sh;
        logic [NSW-1:0] pm;
        n_nsq = '0;
        for (int i = 0; i < 3; i++) begin
            sh      = r_mag[i] >> r_s;
            pm      = {1'b0, sh[NS_MAG-1:0]};
            n_ns[i] = r_sgn[i] ? -pm : pm;
            n_nsq   = n_nsq + NSQW'($signed(r_ns[i])) * NSQW'($signed(r_ns[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        r_e1    <= n_e1;
        r_e2    <= n_e2;
        r_u     <= n_u;
        r_n     <= n_n;
        r_mag   <= n_mag;
        for (int i = 0; i < 3; i++) begin
            r_sgn[i] <= r_n[i][NW-1];
        end
        r_m     <= n_m;
        r_s     <= n_s;
        r_degen <= (r_m == '0);
        r_ns    <= n_ns;
        r_nsq   <= n_nsq;
        r_rhs   <= RHSW'(r_nsq) << (2 * COORD_FRAC_BITS);
    end

    always_comb begin
        o_plane.vert   = vv;
        o_plane.side_u = r_u;
        o_plane.ns     = r_ns;
        o_plane.rhs    = r_rhs;
        o_plane.degen  = r_degen;
        o_plane.quad   = r_quad;
    end

endmodule
`default_nettype wire

// File: rtl/core/rpi_setup.sv
`default_nettype none
module rpi_setup import rpi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_vec              i_p0,
    input  t_vec              i_dir,
    input  t_plane            i_plane,
    output logic              o_valid,
    output logic [DMAGW-1:0]  o_den_mag,
    output logic [NMAGW-1:0]  o_num_mag,
    output t_vec              o_dir,
    output t_side             o_side
);
    logic [4:0]              r_vld;
    t_vec                    r_s1_p0, r_s2_p0, r_s3_p0, r_s4_p0;
    t_vec                    r_s1_dir, r_s2_dir, r_s3_dir, r_s4_dir, r_s5_dir;
    logic [2:0][DW-1:0]      r_s1_diff, n_diff;
    logic [DENW-1:0]         r_s2_den, n_den;
    logic [NUMW-1:0]         r_s2_num, n_num;
    logic [DMAGW-1:0]        r_s3_den, r_s4_den, r_s5_den, n_den_abs;
    logic [NUMW-1:0]         r_s3_num, r_s4_num, n_num_f;
    logic [LHSW-1:0]         r_s3_lhs, n_lhs;
    logic [SQW-1:0]          r_s4_sq;
    logic                    r_s4_small;
    t_side                   r_s5_side, n_side;
    logic [NMAGW-1:0]        r_s5_num;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_diff[i] = csub(i_plane.vert[0][i], i_p0[i]);
        end
    end

    always_comb begin
        n_den = '0;
        n_num = '0;
        for (int i = 0; i < 3; i++) begin
            n_den = n_den + DENW'($signed(r_s1_dir[i])) * DENW'($signed(i_plane.ns[i]));
            n_num = n_num + NUMW'($signed(r_s1_diff[i])) * NUMW'($signed(i_plane.ns[i]));
        end
    end

    always_comb begin
        logic [DENW-1:0] dabs;
        dabs      = r_s2_den[DENW-1] ? -r_s2_den : r_s2_den;
        n_den_abs = dabs[DMAGW-1:0];
        n_num_f   = r_s2_den[DENW-1] ? -r_s2_num : r_s2_num;
        n_lhs     = LHSW'(n_den_abs) * LHSW'(PAR_SCALE);
    end

    always_comb begin
        n_side.p0       = r_s4_p0;
        for (int i = 0; i < 3; i++) begin
            n_side.dir_neg[i] = r_s4_dir[i][CW-1];
        end
        n_side.parallel = r_s4_small && (r_s4_sq < i_plane.rhs);
        n_side.behind   = r_s4_num[NUMW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_p0    <= i_p0;
            r_s1_dir   <= i_dir;
            r_s1_diff  <= n_diff;
            r_s2_p0    <= r_s1_p0;
            r_s2_dir   <= r_s1_dir;
            r_s2_den   <= n_den;
            r_s2_num   <= n_num;
            r_s3_p0    <= r_s2_p0;
            r_s3_dir   <= r_s2_dir;
            r_s3_den   <= n_den_abs;
            r_s3_num   <= n_num_f;
            r_s3_lhs   <= n_lhs;
            r_s4_p0    <= r_s3_p0;
            r_s4_dir   <= r_s3_dir;
            r_s4_den   <= r_s3_den;
            r_s4_num   <= r_s3_num;
            r_s4_small <= (r_s3_lhs[LHSW-1:SQW/2] == '0);
            r_s4_sq    <= SQW'(r_s3_lhs[SQW/2-1:0]) * SQW'(r_s3_lhs[SQW/2-1:0]);
            r_s5_side  <= n_side;
            r_s5_dir   <= r_s4_dir;
            r_s5_den   <= r_s4_den;
            r_s5_num   <= r_s4_num[NMAGW-1:0];
        end
    end

    assign o_valid   = r_vld[4];
    assign o_den_mag = r_s5_den;
    assign o_num_mag = r_s5_num;
    assign o_dir     = r_s5_dir;
    assign o_side    = r_s5_side;

endmodule
`default_nettype wire

// File: rtl/core/rpi_div.sv
`default_nettype none
module rpi_div import rpi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [DMAGW-1:0]      i_den_mag,
    input  logic [NMAGW-1:0]      i_num_mag,
    input  t_vec                  i_dir,
    input  t_side                 i_side,
    output logic                  o_valid,
    output logic [3:0][QB-1:0]    o_quot,
    output logic [3:0]            o_ovf,
    output t_side                 o_side
);
    logic [QB+1:0]           r_vld;
    logic [3:0][XW-1:0]      r_x0, n_x0;
    logic [DMAGW-1:0]        r_d0;
    t_side                   r_sd0;
    logic [3:0]              n_ovf0;

    logic [3:0][XW-1:0]      r_rem [QB+1];
    logic [3:0][QB-1:0]      r_q   [QB+1];
    logic [3:0]              r_ovf [QB+1];
    logic [DMAGW-1:0]        r_dv  [QB+1];
    t_side                   r_sd  [QB+1];
    logic [3:0][XW-1:0]      n_rem [QB];
    logic [3:0][QB-1:0]      n_q   [QB];
    logic [DSW-1:0]          dsh   [QB];

    always_comb begin
        logic [CW-1:0] dm;
        n_x0[0] = XW'(i_num_mag) << TQ_FRAC;
        for (int i = 0; i < 3; i++) begin
            dm        = i_dir[i][CW-1] ? -i_dir[i] : i_dir[i];
            n_x0[i+1] = XW'(dm) * XW'(i_num_mag);
        end
        for (int l = 0; l < 4; l++) begin
            n_ovf0[l] = DSW'(r_x0[l]) >= (DSW'(r_d0) << QB);
        end
    end

    always_comb begin
        logic ge;
        for (int g = 0; g < QB; g++) begin
            dsh[g] = DSW'(r_dv[g]) << (QB - 1 - g);
            for (int l = 0; l < 4; l++) begin
                ge          = DSW'(r_rem[g][l]) >= dsh[g];
                n_rem[g][l] = ge ? r_rem[g][l] - dsh[g][XW-1:0] : r_rem[g][l];
                n_q[g][l]   = {r_q[g][l][QB-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QB:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x0     <= n_x0;
            r_d0     <= i_den_mag;
            r_sd0    <= i_side;
            r_rem[0] <= r_x0;
            r_q[0]   <= '0;
            r_ovf[0] <= n_ovf0;
            r_dv[0]  <= r_d0;
            r_sd[0]  <= r_sd0;
            for (int g = 0; g < QB; g++) begin
                r_rem[g+1] <= n_rem[g];
                r_q[g+1]   <= n_q[g];
                r_ovf[g+1] <= r_ovf[g];
                r_dv[g+1]  <= r_dv[g];
                r_sd[g+1]  <= r_sd[g];
            end
        end
    end

    assign o_valid = r_vld[QB+1];
    assign o_quot  = r_q[QB];
    assign o_ovf   = r_ovf[QB];
    assign o_side  = r_sd[QB];

endmodule
`default_nettype wire

// File: rtl/core/rpi_edge.sv
`default_nettype none
module rpi_edge import rpi_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [3:0][QB-1:0]  i_quot,
    input  logic [3:0]          i_ovf,
    input  t_side               i_side,
    input  t_plane              i_plane,
    output logic                o_valid,
    output logic                o_hit,
    output logic [TQW-1:0]      o_distance,
    output t_status             o_status
);
    logic [4:0]                 r_vld;
    t_vec                       r_e0_q, n_q;
    logic                       n_oor;
    logic [4:0]                 r_par, r_beh, r_oor;
    logic [4:0][TQW-1:0]        r_tq;
    logic [3:0][2:0][DW-1:0]    r_w, n_w;
    logic [3:0][2:0][NW-1:0]    r_c, n_c;
    logic [3:0][2:0][KW-1:0]    r_p, n_p;
    logic [3:0]                 r_pos, r_neg, n_pos, n_neg;
    logic                       in_poly;

    always_comb begin
        logic [QFW-1:0] mq, sq, qf;
        n_oor = 1'b0;
        for (int i = 0; i < 3; i++) begin
            mq     = QFW'(i_quot[i+1]);
            sq     = i_side.dir_neg[i] ? -mq : mq;
            qf     = QFW'($signed(i_side.p0[i])) + sq;
            n_q[i] = qf[CW-1:0];
            if (i_ovf[i+1] || !((qf[QFW-1:CW-1] == '0) || (qf[QFW-1:CW-1] == '1))) begin
                n_oor = 1'b1;
            end
        end
    end

    always_comb begin
        logic [KW-1:0] sum;
        for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 3; i++) begin
                n_w[k][i] = csub(r_e0_q[i], i_plane.vert[k][i]);
                n_p[k][i] = KW'($signed(r_c[k][i])) * KW'($signed(i_plane.ns[i]));
            end
            n_c[k][0] = xprod(i_plane.side_u[k][1], r_w[k][2], i_plane.side_u[k][2], r_w[k][1]);
            n_c[k][1] = xprod(i_plane.side_u[k][2], r_w[k][0], i_plane.side_u[k][0], r_w[k][2]);
            n_c[k][2] = xprod(i_plane.side_u[k][0], r_w[k][1], i_plane.side_u[k][1], r_w[k][0]);
            sum      = r_p[k][0] + r_p[k][1] + r_p[k][2];
            n_pos[k] = !sum[KW-1] && (sum != '0);
            n_neg[k] = sum[KW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e0_q   <= n_q;
            r_w      <= n_w;
            r_c      <= n_c;
            r_p      <= n_p;
            r_pos    <= n_pos;
            r_neg    <= n_neg;
            r_par    <= {r_par[3:0], i_side.parallel};
            r_beh    <= {r_beh[3:0], i_side.behind};
            r_oor    <= {r_oor[3:0], n_oor};
            r_tq[0]  <= i_ovf[0] ? '1 : i_quot[0];
            r_tq[4:1] <= r_tq[3:0];
        end
    end

    always_comb begin
        if (i_plane.quad) begin
            in_poly = (&r_pos) || (&r_neg);
        end else begin
            in_poly = (&r_pos[2:0]) || (&r_neg[2:0]);
        end
        priority if (i_plane.degen) begin
            o_status = ST_OUTSIDE;
        end else if (r_par[4]) begin
            o_status = ST_PARALLEL;
        end else if (r_beh[4]) begin
            o_status = ST_BEHIND;
        end else if (r_oor[4] || !in_poly) begin
            o_status = ST_OUTSIDE;
        end else begin
            o_status = ST_HIT;
        end
        o_hit      = (o_status == ST_HIT);
        o_distance = o_hit ? r_tq[4] : '0;
    end

    assign o_valid = r_vld[4];

endmodule
`default_nettype wire

// File: rtl/core/ray_polygon_intersect.sv
// Ray against a configured triangle or quad, one ray per transfer.
// Configuration: write vertex_a..vertex_d (x,y,z packed Q10.10) and
// quad_mode through i_cfg_we / i_cfg_index / i_cfg_data while no ray is
// in flight. After each write, and after reset, o_stall stays high on the
// ray input until the plane setup is done.
// Input channel: i_valid / o_stall carries origin and direction.
// Output channel: o_valid / i_stall carries hit, distance (Q16.16) and
// status (hit, parallel, behind origin, outside polygon).
// Path: ray setup, then the 32-stage restoring divider that forms t and
// the hit point, then the edge tests and the output register.
// Throughput: one ray per cycle while o_stall is low; each stage is registered.
// When the receiver stalls a waiting result, the whole pipeline holds and
// the input is stalled; nothing is dropped or repeated.
// Reset clears the vertices and quad_mode to zero and empties the pipe.
`default_nettype none
module ray_polygon_intersect import rpi_pkg::*; #(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_IDXW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0]   i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [CW-1:0]       i_origin_x,
    input  logic [CW-1:0]       i_origin_y,
    input  logic [CW-1:0]       i_origin_z,
    input  logic [CW-1:0]       i_dir_x,
    input  logic [CW-1:0]       i_dir_y,
    input  logic [CW-1:0]       i_dir_z,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_hit,
    output logic [TQW-1:0]      o_distance,
    output logic [1:0]          o_status
);
    t_plane                plane;
    logic                  busy, en, accept;
    logic                  su_valid, dv_valid, eg_valid;
    logic [DMAGW-1:0]      su_den;
    logic [NMAGW-1:0]      su_num;
    t_vec                  su_dir;
    t_side                 su_side, dv_side;
    logic [3:0][QB-1:0]    dv_quot;
    logic [3:0]            dv_ovf;
    logic                  eg_hit;
    logic [TQW-1:0]        eg_dist;
    t_status               eg_status;

    logic                  r_out_valid;
    logic                  r_hit;
    logic [TQW-1:0]        r_distance;
    t_status               r_status;

    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en || busy;
    assign accept  = i_valid && !o_stall;

    rpi_plane #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_plane (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_plane     (plane),
        .o_busy      (busy)
    );

    rpi_setup u_setup (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (accept),
        .i_p0      ({i_origin_z, i_origin_y, i_origin_x}),
        .i_dir     ({i_dir_z, i_dir_y, i_dir_x}),
        .i_plane   (plane),
        .o_valid   (su_valid),
        .o_den_mag (su_den),
        .o_num_mag (su_num),
        .o_dir     (su_dir),
        .o_side    (su_side)
    );

    rpi_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (su_valid),
        .i_den_mag (su_den),
        .i_num_mag (su_num),
        .i_dir     (su_dir),
        .i_side    (su_side),
        .o_valid   (dv_valid),
        .o_quot    (dv_quot),
        .o_ovf     (dv_ovf),
        .o_side    (dv_side)
    );

    rpi_edge u_edge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (dv_valid),
        .i_quot     (dv_quot),
        .i_ovf      (dv_ovf),
        .i_side     (dv_side),
        .i_plane    (plane),
        .o_valid    (eg_valid),
        .o_hit      (eg_hit),
        .o_distance (eg_dist),
        .o_status   (eg_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= eg_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit      <= eg_hit;
            r_distance <= eg_dist;
            r_status   <= eg_status;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_hit      = r_hit;
    assign o_distance = r_distance;
    assign o_status   = r_status;

    a_hit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hit == (r_status == ST_HIT)))
        else $error("hit flag disagrees with status");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_distance == '0))
        else $error("distance nonzero on a miss");

    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_stall)
        else $error("ray taken while plane setup is running");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule
`default_nettype wire
